// File: hdl/newton_cubic_root_solver_unit_defines.svh
// Assertion macros shared by the Newton cubic root solver RTL.
`ifndef NEWTON_CUBIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`define NEWTON_CUBIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define NCRS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define NCRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define NCRS_ASSERT_SAME(lbl, ante, cons, msg)
`define NCRS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/ncrs_pkg.sv
// Types, constants and the evaluation microcode of the Newton cubic root solver.
package ncrs_pkg;
	localparam int DATA_W = 64;
	localparam int TOL_W = 41;
	localparam int CNT_W = 16;
	localparam int IDX_W = 3;
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] PC_LAST = 4'd10;

	typedef enum logic [1:0] {
		ST_CONV = 2'd0,
		ST_LIMIT = 2'd1,
		ST_ZDER = 2'd2,
		ST_OVF = 2'd3
	} status_t;

	typedef enum logic [IDX_W-1:0] {
		REG_COEF_SQUARE = 3'd0,
		REG_COEF_LINEAR = 3'd1,
		REG_COEF_CONSTANT = 3'd2,
		REG_TOLERANCE = 3'd3,
		REG_ITER_LIMIT = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_ADD = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_NEXT = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		SRC_X = 3'd0,
		SRC_T = 3'd1,
		SRC_U = 3'd2,
		SRC_C2 = 3'd3,
		SRC_C1 = 3'd4,
		SRC_C0 = 3'd5
	} src_t;

	typedef enum logic [1:0] {
		DST_T = 2'd0,
		DST_U = 2'd1,
		DST_PD = 2'd2,
		DST_P = 2'd3
	} dst_t;

	typedef struct packed {
		op_t kind;
		src_t a;
		src_t b;
		dst_t dst;
	} uop_t;

	typedef struct packed {
		logic load;
		op_t op;
		src_t a;
		src_t b;
		dst_t dst;
		logic out_load;
		status_t out_status;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic ovf;
		logic pd_zero;
		logic tol_ok;
		logic lim_hit;
		logic out_busy;
	} stat_t;

	function automatic uop_t uop(input logic [PC_W-1:0] pc);
		uop_t u;
		u = '{OP_ADD, SRC_U, SRC_C0, DST_P};
		unique case (pc)
			4'd0: u = '{OP_ADD, SRC_X, SRC_X, DST_T};
			4'd1: u = '{OP_ADD, SRC_T, SRC_X, DST_T};
			4'd2: u = '{OP_ADD, SRC_C2, SRC_C2, DST_U};
			4'd3: u = '{OP_ADD, SRC_T, SRC_U, DST_T};
			4'd4: u = '{OP_MUL, SRC_T, SRC_X, DST_T};
			4'd5: u = '{OP_ADD, SRC_T, SRC_C1, DST_PD};
			4'd6: u = '{OP_ADD, SRC_X, SRC_C2, DST_U};
			4'd7: u = '{OP_MUL, SRC_U, SRC_X, DST_U};
			4'd8: u = '{OP_ADD, SRC_U, SRC_C1, DST_U};
			4'd9: u = '{OP_MUL, SRC_U, SRC_X, DST_U};
			default: u = '{OP_ADD, SRC_U, SRC_C0, DST_P};
		endcase
		return u;
	endfunction
endpackage

// File: hdl/ncrs_in_if.sv
// Input channel carrying one start value per transaction.
interface ncrs_in_if;
	logic valid;
	logic ready;
	logic signed [ncrs_pkg::DATA_W-1:0] start_value;

	modport source (output valid, output start_value, input ready);
	modport sink (input valid, input start_value, output ready);
endinterface

// File: hdl/ncrs_out_if.sv
// Output channel carrying one root, status and step count per transaction.
interface ncrs_out_if;
	logic valid;
	logic ready;
	logic signed [ncrs_pkg::DATA_W-1:0] root;
	logic [1:0] status;
	logic [ncrs_pkg::CNT_W-1:0] step_count;

	modport source (output valid, output root, output status, output step_count, input ready);
	modport sink (input valid, input root, input status, input step_count, output ready);
endinterface

// File: hdl/ncrs_ctrl.sv
// Controller state machine sequencing the Newton steps.
module ncrs_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input ncrs_pkg::stat_t stat,
	output ncrs_pkg::cmd_t cmd
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_EVAL = 8'b0000_0010,
		S_WAIT = 8'b0000_0100,
		S_CHK = 8'b0000_1000,
		S_DWAIT = 8'b0001_0000,
		S_STEP = 8'b0010_0000,
		S_JUDGE = 8'b0100_0000,
		S_FINISH = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic [ncrs_pkg::PC_W-1:0] pc_q, pc_d;
	ncrs_pkg::status_t fin_q, fin_d;
	ncrs_pkg::uop_t u;

	always_comb begin
		u = ncrs_pkg::uop(pc_q);
		cmd = '0;
		state_d = state_q;
		pc_d = pc_q;
		fin_d = fin_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					pc_d = '0;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.op = u.kind;
				cmd.a = u.a;
				cmd.b = u.b;
				cmd.dst = u.dst;
				if (u.kind == ncrs_pkg::OP_MUL) begin
					state_d = S_WAIT;
				end else if (pc_q == ncrs_pkg::PC_LAST) begin
					state_d = S_CHK;
				end else begin
					pc_d = pc_q + 1'b1;
				end
			end
			S_WAIT: begin
				if (stat.mul_done) begin
					pc_d = pc_q + 1'b1;
					state_d = S_EVAL;
				end
			end
			S_CHK: begin
				priority if (stat.ovf) begin
					fin_d = ncrs_pkg::ST_OVF;
					state_d = S_FINISH;
				end else if (stat.pd_zero) begin
					fin_d = ncrs_pkg::ST_ZDER;
					state_d = S_FINISH;
				end else begin
					cmd.op = ncrs_pkg::OP_DIV;
					state_d = S_DWAIT;
				end
			end
			S_DWAIT: begin
				if (stat.div_done) begin
					state_d = S_STEP;
				end
			end
			S_STEP: begin
				cmd.op = ncrs_pkg::OP_NEXT;
				state_d = S_JUDGE;
			end
			S_JUDGE: begin
				priority if (stat.ovf) begin
					fin_d = ncrs_pkg::ST_OVF;
					state_d = S_FINISH;
				end else if (stat.tol_ok) begin
					fin_d = ncrs_pkg::ST_CONV;
					state_d = S_FINISH;
				end else if (stat.lim_hit) begin
					fin_d = ncrs_pkg::ST_LIMIT;
					state_d = S_FINISH;
				end else begin
					pc_d = '0;
					state_d = S_EVAL;
				end
			end
			S_FINISH: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					cmd.out_status = fin_q;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			fin_q <= ncrs_pkg::ST_CONV;
		end else begin
			state_q <= state_d;
			pc_q <= pc_d;
			fin_q <= fin_d;
		end
	end
endmodule

// File: hdl/ncrs_datapath.sv
// Datapath: configuration registers, working registers, multiplier, divider and output stage.
module ncrs_datapath #(
	parameter int WORD_WIDTH = 64,
	parameter int FRACTION_BITS = 40
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ncrs_pkg::IDX_W-1:0] cfg_index,
	input logic [ncrs_pkg::DATA_W-1:0] cfg_wdata,
	input logic signed [ncrs_pkg::DATA_W-1:0] start_value,
	input ncrs_pkg::cmd_t cmd,
	output ncrs_pkg::stat_t stat,
	ncrs_out_if.source out_ch
);
	localparam int DW = ncrs_pkg::DATA_W;
	localparam int SH = DW - WORD_WIDTH;
	localparam logic [2*DW-1:0] LIM = (2*DW)'(1) << (WORD_WIDTH - 1);

	function automatic logic [DW-1:0] sext(input logic [DW-1:0] v);
		return DW'($signed(v << SH) >>> SH);
	endfunction

	function automatic logic fits(input logic [DW:0] s);
		logic [DW:0] t;
		t = (DW+1)'($signed(s) >>> (WORD_WIDTH - 1));
		return (t == '0) || (t == '1);
	endfunction

	function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
		return v[DW-1] ? (DW)'(-v) : v;
	endfunction

	logic [DW-1:0] c2_q, c1_q, c0_q;
	logic [ncrs_pkg::TOL_W-1:0] tol_q;
	logic [ncrs_pkg::CNT_W-1:0] lim_q;
	logic [DW-1:0] x_q, t_q, u_q, pd_q, p_q, d_q;
	logic [ncrs_pkg::CNT_W-1:0] n_q;
	logic ovf_q;

	logic [DW-1:0] opa, opb;
	logic [DW:0] sum;

	logic mul_busy_q, mneg_q;
	logic mul_done_q, div_done_q;
	logic [2:0] mcnt_q;
	logic [DW-1:0] ma_q, mb_q;
	logic [63:0] pp_q;
	logic [1:0] psh_q;
	logic [2*DW-1:0] acc_q, mshift;
	ncrs_pkg::dst_t mdst_q;
	logic [31:0] mpa, mpb;

	logic div_busy_q, dneg_q;
	logic [7:0] dcnt_q;
	logic [2*DW-1:0] nq_q;
	logic [DW-1:0] rem_q, dm_q;
	logic [DW:0] r2;
	logic r_ge;

	logic out_valid_q;
	logic [DW-1:0] root_q;
	logic [1:0] ost_q;
	logic [ncrs_pkg::CNT_W-1:0] ocnt_q;

	function automatic logic [DW-1:0] pick(input ncrs_pkg::src_t s);
		logic [DW-1:0] v;
		unique case (s)
			ncrs_pkg::SRC_X: v = x_q;
			ncrs_pkg::SRC_T: v = t_q;
			ncrs_pkg::SRC_U: v = u_q;
			ncrs_pkg::SRC_C2: v = sext(c2_q);
			ncrs_pkg::SRC_C1: v = sext(c1_q);
			ncrs_pkg::SRC_C0: v = sext(c0_q);
			default: v = x_q;
		endcase
		return v;
	endfunction

	always_comb begin
		opa = (cmd.op == ncrs_pkg::OP_NEXT) ? x_q : pick(cmd.a);
		opb = (cmd.op == ncrs_pkg::OP_NEXT) ? d_q : pick(cmd.b);
		sum = {opa[DW-1], opa} + {opb[DW-1], opb};
		mpa = mcnt_q[1] ? ma_q[DW-1:32] : ma_q[31:0];
		mpb = mcnt_q[0] ? mb_q[DW-1:32] : mb_q[31:0];
		mshift = acc_q >> FRACTION_BITS;
		r2 = {rem_q, nq_q[2*DW-1]};
		r_ge = r2 >= {1'b0, dm_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c2_q <= 64'hFFFF_FD00_0000_0000;
			c1_q <= 64'hFFFF_FF00_0000_0000;
			c0_q <= 64'h0000_0300_0000_0000;
			tol_q <= 41'd1;
			lim_q <= 16'hFFFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ncrs_pkg::REG_COEF_SQUARE: c2_q <= cfg_wdata;
				ncrs_pkg::REG_COEF_LINEAR: c1_q <= cfg_wdata;
				ncrs_pkg::REG_COEF_CONSTANT: c0_q <= cfg_wdata;
				ncrs_pkg::REG_TOLERANCE: tol_q <= cfg_wdata[ncrs_pkg::TOL_W-1:0];
				ncrs_pkg::REG_ITER_LIMIT: lim_q <= cfg_wdata[ncrs_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			div_busy_q <= 1'b0;
			ovf_q <= 1'b0;
			mcnt_q <= '0;
			dcnt_q <= '0;
			mul_done_q <= 1'b0;
			div_done_q <= 1'b0;
		end else begin
			mul_done_q <= 1'b0;
			div_done_q <= 1'b0;
			if (cmd.load) begin
				x_q <= sext(start_value);
				n_q <= '0;
				ovf_q <= 1'b0;
			end
			if (cmd.op == ncrs_pkg::OP_ADD) begin
				if (!fits(sum)) ovf_q <= 1'b1;
				unique case (cmd.dst)
					ncrs_pkg::DST_T: t_q <= sum[DW-1:0];
					ncrs_pkg::DST_U: u_q <= sum[DW-1:0];
					ncrs_pkg::DST_PD: pd_q <= sum[DW-1:0];
					ncrs_pkg::DST_P: p_q <= sum[DW-1:0];
					default: ;
				endcase
			end
			if (cmd.op == ncrs_pkg::OP_NEXT) begin
				if (!ovf_q && fits(sum)) begin
					x_q <= sum[DW-1:0];
					n_q <= n_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.op == ncrs_pkg::OP_MUL) begin
				mul_busy_q <= 1'b1;
				mcnt_q <= '0;
				ma_q <= mag(opa);
				mb_q <= mag(opb);
				mneg_q <= opa[DW-1] ^ opb[DW-1];
				mdst_q <= cmd.dst;
				acc_q <= '0;
			end else if (mul_busy_q) begin
				mcnt_q <= mcnt_q + 1'b1;
				if (mcnt_q < 3'd4) begin
					pp_q <= {32'd0, mpa} * {32'd0, mpb};
					psh_q <= {1'b0, mcnt_q[1]} + {1'b0, mcnt_q[0]};
				end
				if (mcnt_q >= 3'd1 && mcnt_q <= 3'd4) begin
					acc_q <= acc_q + ((2*DW)'(pp_q) << (32 * psh_q));
				end
				if (mcnt_q == 3'd5) begin
					mul_busy_q <= 1'b0;
					mul_done_q <= 1'b1;
					if (mneg_q ? (mshift > LIM) : (mshift >= LIM)) ovf_q <= 1'b1;
					unique case (mdst_q)
						ncrs_pkg::DST_T: t_q <= mneg_q ? DW'(-mshift[DW-1:0]) : mshift[DW-1:0];
						ncrs_pkg::DST_U: u_q <= mneg_q ? DW'(-mshift[DW-1:0]) : mshift[DW-1:0];
						ncrs_pkg::DST_PD: pd_q <= mneg_q ? DW'(-mshift[DW-1:0]) : mshift[DW-1:0];
						ncrs_pkg::DST_P: p_q <= mneg_q ? DW'(-mshift[DW-1:0]) : mshift[DW-1:0];
						default: ;
					endcase
				end
			end
			if (cmd.op == ncrs_pkg::OP_DIV) begin
				div_busy_q <= 1'b1;
				dcnt_q <= '0;
				nq_q <= (2*DW)'(mag(p_q)) << FRACTION_BITS;
				dm_q <= mag(pd_q);
				rem_q <= '0;
				dneg_q <= (p_q[DW-1] == pd_q[DW-1]);
			end else if (div_busy_q) begin
				if (dcnt_q[7]) begin
					div_busy_q <= 1'b0;
					div_done_q <= 1'b1;
					if (dneg_q ? (nq_q > LIM) : (nq_q >= LIM)) ovf_q <= 1'b1;
					d_q <= dneg_q ? DW'(-nq_q[DW-1:0]) : nq_q[DW-1:0];
				end else begin
					dcnt_q <= dcnt_q + 1'b1;
					rem_q <= r_ge ? DW'(r2 - {1'b0, dm_q}) : r2[DW-1:0];
					nq_q <= {nq_q[2*DW-2:0], r_ge};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
			root_q <= x_q;
			ost_q <= cmd.out_status;
			ocnt_q <= n_q;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat = '{
		mul_done: mul_done_q,
		div_done: div_done_q,
		ovf: ovf_q,
		pd_zero: (pd_q == '0),
		tol_ok: (mag(d_q) <= DW'(tol_q)),
		lim_hit: (n_q >= lim_q),
		out_busy: (out_valid_q && !out_ch.ready)
	};

	assign out_ch.valid = out_valid_q;
	assign out_ch.root = root_q;
	assign out_ch.status = ost_q;
	assign out_ch.step_count = ocnt_q;
endmodule

// File: hdl/newton_cubic_root_solver_unit.sv
// Top level of the Newton-Raphson cubic root solver.
//  channel  direction  transaction payload
//  in_ch    sink       start_value
//  out_ch   source     root, status, step_count
//  cfg      write      cfg_we, cfg_index, cfg_wdata
// One start value is worked at a time; a new one is taken once the last result is queued.
// Each Newton step runs eight additions and three multiplies, then a check, a one-bit-per-cycle
// divide with hand-over, an update and a decision.
// A run accepts the start value, repeats the step until a check or decision ends it, then loads the result.
// Reset restores the default polynomial, tolerance and limit; no clearing pass is needed.
// A stalled output holds its result while the next run proceeds until it needs the register.
`include "newton_cubic_root_solver_unit_defines.svh"
module newton_cubic_root_solver_unit #(
	parameter int WORD_WIDTH = 64,
	parameter int FRACTION_BITS = 40
) (
	input logic clk,
	input logic arst_n,
	ncrs_in_if.sink in_ch,
	ncrs_out_if.source out_ch,
	input logic cfg_we,
	input logic [ncrs_pkg::IDX_W-1:0] cfg_index,
	input logic [ncrs_pkg::DATA_W-1:0] cfg_wdata
);
	ncrs_pkg::cmd_t cmd;
	ncrs_pkg::stat_t stat;

	ncrs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.stat(stat),
		.cmd(cmd)
	);

	ncrs_datapath #(
		.WORD_WIDTH(WORD_WIDTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.start_value(in_ch.start_value),
		.cmd(cmd),
		.stat(stat),
		.out_ch(out_ch)
	);

	`NCRS_ASSERT_NEXT(a_busy, in_ch.valid && in_ch.ready, !in_ch.ready, "Input taken mid-run.")
	`NCRS_ASSERT_SAME(a_steps, out_ch.valid && out_ch.status <= ncrs_pkg::ST_LIMIT, |out_ch.step_count, "No step counted.")
endmodule

// File: test/newton_cubic_root_solver_unit_tb.sv
// Self-checking testbench for the Newton-Raphson cubic root solver: directed table, then random.
module newton_cubic_root_solver_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [63:0] ONE = 64'sd1099511627776;
	localparam logic signed [63:0] WORD_MAX = 64'sh7fffffffffffffff;
	localparam logic signed [63:0] WORD_MIN = 64'sh8000000000000000;
	localparam logic [40:0] TOL_MAX = 41'h10000000000;
	localparam logic [ncrs_pkg::IDX_W-1:0] UNUSED_INDEX = 3'd7;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 50;
	localparam int CALM_FROM = 520;

	typedef struct {
		logic signed [63:0] root;
		ncrs_pkg::status_t status;
		logic [15:0] steps;
	} root_result_t;

	typedef struct {
		logic reconfigure;
		logic signed [63:0] c2, c1, c0;
		logic [40:0] tol;
		logic [15:0] lim;
		logic signed [63:0] start;
		logic typed;
		logic signed [63:0] root;
		ncrs_pkg::status_t status;
		logic [15:0] steps;
	} stimulus_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ncrs_pkg::IDX_W-1:0] cfg_index = '0;
	logic [ncrs_pkg::DATA_W-1:0] cfg_wdata = '0;

	ncrs_in_if in_ch ();
	ncrs_out_if out_ch ();

	newton_cubic_root_solver_unit i_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	logic signed [63:0] coef_sq = -64'sd3298534883328;
	logic signed [63:0] coef_lin = -64'sd1099511627776;
	logic signed [63:0] coef_const = 64'sd3298534883328;
	logic [40:0] tol_reg = 41'd1;
	logic [15:0] lim_reg = 16'd65535;

	root_result_t expected_roots[$];
	int mismatches = 0;
	int items_sent = 0;
	int idle_cycles = 0;
	logic calm = 1'b0;

	always #10 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.start_value = '0;
		out_ch.ready = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic logic sum_fits(input logic signed [63:0] a, b,
			output logic signed [63:0] r);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		r = s[63:0];
		return s[64] == s[63];
	endfunction

	function automatic logic magnitude_fits(input logic neg, input logic [127:0] m,
			output logic signed [63:0] r);
		if (neg) begin
			r = -m[63:0];
			return m <= 128'h8000000000000000;
		end
		r = m[63:0];
		return m < 128'h8000000000000000;
	endfunction

	function automatic logic [127:0] abs_wide(input logic signed [63:0] v);
		logic signed [127:0] w;
		w = v;
		return w < 0 ? -w : w;
	endfunction

	function automatic logic product_fits(input logic signed [63:0] a, b,
			output logic signed [63:0] r);
		logic [127:0] m;
		m = (abs_wide(a) * abs_wide(b)) >> 40;
		return magnitude_fits(a[63] ^ b[63], m, r);
	endfunction

	function automatic logic newton_step_fits(input logic signed [63:0] p, pd,
			output logic signed [63:0] r);
		logic [127:0] m;
		m = (abs_wide(p) << 40) / abs_wide(pd);
		return magnitude_fits(p[63] == pd[63], m, r);
	endfunction

	function automatic root_result_t solve_cubic(input logic signed [63:0] start);
		root_result_t res;
		logic signed [63:0] x, t, u, pd, p, d, nx;
		logic ok;
		logic [15:0] n;
		x = start;
		n = 0;
		forever begin
			ok = sum_fits(x, x, t) && sum_fits(t, x, t) && sum_fits(coef_sq, coef_sq, u)
				&& sum_fits(t, u, t) && product_fits(t, x, t) && sum_fits(t, coef_lin, pd)
				&& sum_fits(x, coef_sq, u) && product_fits(u, x, u)
				&& sum_fits(u, coef_lin, u) && product_fits(u, x, u)
				&& sum_fits(u, coef_const, p);
			if (!ok) begin
				res.status = ncrs_pkg::ST_OVF;
				break;
			end
			if (pd == 0) begin
				res.status = ncrs_pkg::ST_ZDER;
				break;
			end
			if (!newton_step_fits(p, pd, d) || !sum_fits(x, d, nx)) begin
				res.status = ncrs_pkg::ST_OVF;
				break;
			end
			x = nx;
			n++;
			if (abs_wide(d) <= tol_reg) begin
				res.status = ncrs_pkg::ST_CONV;
				break;
			end
			if (n >= lim_reg) begin
				res.status = ncrs_pkg::ST_LIMIT;
				break;
			end
		end
		res.root = x;
		res.steps = n;
		return res;
	endfunction

	task automatic write_reg(input logic [ncrs_pkg::IDX_W-1:0] idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic load_polynomial(input logic signed [63:0] c2, c1, c0,
			input logic [40:0] tol, input logic [15:0] lim);
		write_reg(ncrs_pkg::REG_COEF_SQUARE, c2);
		write_reg(ncrs_pkg::REG_COEF_LINEAR, c1);
		write_reg(ncrs_pkg::REG_COEF_CONSTANT, c0);
		write_reg(ncrs_pkg::REG_TOLERANCE, {23'd0, tol});
		write_reg(ncrs_pkg::REG_ITER_LIMIT, {48'd0, lim});
		cfg_we <= 1'b0;
		coef_sq = c2;
		coef_lin = c1;
		coef_const = c0;
		tol_reg = tol;
		lim_reg = lim;
	endtask

	task automatic drain_roots();
		in_ch.valid <= 1'b0;
		while (expected_roots.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_start(input logic signed [63:0] v, input logic typed,
			input root_result_t typed_res);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.start_value <= v;
		do
			@(posedge clk);
		while (!in_ch.ready);
		expected_roots.push_back(typed ? typed_res : solve_cubic(v));
		items_sent++;
	endtask

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			if (expected_roots.size() == 0) begin
				report_mismatch("result arrived with none outstanding");
			end else begin
				root_result_t e;
				e = expected_roots.pop_front();
				if (out_ch.root !== e.root)
					report_mismatch($sformatf("root %h, expected %h", out_ch.root, e.root));
				if (out_ch.status !== e.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						out_ch.status, e.status));
				if (out_ch.step_count !== e.steps)
					report_mismatch($sformatf("step_count %0d, expected %0d",
						out_ch.step_count, e.steps));
			end
		end
	end

	initial begin : receiver
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(1, 16);
			end
			out_ch.ready <= (hold == 0) && arst_n;
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 400 * (int'(lim_reg) + 2) + 2000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic signed [63:0] random_word();
		return $signed({$urandom, $urandom});
	endfunction

	function automatic logic signed [63:0] random_coef();
		return $urandom_range(0, 7) == 0 ? random_word() : random_word() >>> 21;
	endfunction

	function automatic logic signed [63:0] random_start();
		case ($urandom_range(0, 9))
			0: return random_word();
			1: return random_word() >>> 22;
			default: return random_word() >>> 18;
		endcase
	endfunction

	function automatic logic [40:0] random_tolerance();
		case ($urandom_range(0, 4))
			0: return 41'd0;
			1: return 41'($urandom_range(0, 1023));
			2: return 41'($urandom) << 8;
			3: return {1'b0, 8'($urandom), 32'($urandom)};
			default: return TOL_MAX;
		endcase
	endfunction

	initial begin : stimulus
		stimulus_row_t rows[$];
		root_result_t r;
		logic [15:0] lim;
		rows = '{
			'{0, 0, 0, 0, 0, 0, WORD_MAX, 1, WORD_MAX, ncrs_pkg::ST_OVF, 0},
			'{0, 0, 0, 0, 0, 0, WORD_MIN, 1, WORD_MIN, ncrs_pkg::ST_OVF, 0},
			'{0, 0, 0, 0, 0, 0, 3 * ONE, 1, 3 * ONE, ncrs_pkg::ST_CONV, 1},
			'{0, 0, 0, 0, 0, 0, ONE, 1, ONE, ncrs_pkg::ST_CONV, 1},
			'{0, 0, 0, 0, 0, 0, -ONE, 1, -ONE, ncrs_pkg::ST_CONV, 1},
			'{1, 0, 0, 0, 0, 5, 0, 1, 0, ncrs_pkg::ST_ZDER, 0},
			'{0, 0, 0, 0, 0, 0, ONE, 0, 0, ncrs_pkg::ST_CONV, 0},
			'{0, 0, 0, 0, 0, 0, -ONE, 0, 0, ncrs_pkg::ST_CONV, 0},
			'{1, WORD_MAX, 0, 0, 1, 3, 0, 1, 0, ncrs_pkg::ST_OVF, 0},
			'{1, WORD_MIN, 0, 0, 1, 3, ONE, 1, ONE, ncrs_pkg::ST_OVF, 0},
			'{1, -3 * ONE, -ONE, 3 * ONE, 0, 0, 2 * ONE, 0, 0, ncrs_pkg::ST_CONV, 0},
			'{0, 0, 0, 0, 0, 0, 5 * ONE, 0, 0, ncrs_pkg::ST_CONV, 0},
			'{1, 0, 0, WORD_MAX, 1000, 4, ONE, 0, 0, ncrs_pkg::ST_CONV, 0},
			'{1, 0, WORD_MIN, WORD_MIN, TOL_MAX, 1, ONE, 0, 0, ncrs_pkg::ST_CONV, 0},
			'{1, 2 * ONE, -ONE, -2 * ONE, TOL_MAX, 65535, 7 * ONE, 0, 0,
				ncrs_pkg::ST_CONV, 0},
			'{0, 0, 0, 0, 0, 0, -7 * ONE, 0, 0, ncrs_pkg::ST_CONV, 0}
		};

		in_ch.valid <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].reconfigure) begin
				drain_roots();
				if (i == 5) begin
					write_reg(UNUSED_INDEX, random_word());
				end
				load_polynomial(rows[i].c2, rows[i].c1, rows[i].c0, rows[i].tol, rows[i].lim);
			end
			r = '{rows[i].root, rows[i].status, rows[i].steps};
			send_start(rows[i].start, rows[i].typed, r);
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_roots();
			lim = ph == 1 ? 16'd0 : 16'($urandom_range(1, 8));
			load_polynomial(random_coef(), random_coef(), random_coef(), random_tolerance(),
				lim);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				calm = items_sent >= CALM_FROM;
				send_start(random_start(), 1'b0, r);
			end
		end

		in_ch.valid <= 1'b0;
		while (expected_roots.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// File: sim.f
+incdir+hdl
hdl/ncrs_pkg.sv
hdl/ncrs_in_if.sv
hdl/ncrs_out_if.sv
hdl/ncrs_ctrl.sv
hdl/ncrs_datapath.sv
hdl/newton_cubic_root_solver_unit.sv
test/newton_cubic_root_solver_unit_tb.sv
